/* hdl/gwm_pkg.sv */
// Shared types, codes and helpers for the wildcard glob matcher.
`timescale 1ns / 1ps

package gwm_pkg;

    localparam int PATTERN_MAX_DEF = 64;
    localparam int SUBJECT_MAX_DEF = 256;
    localparam int BYTE_W          = 8;

    localparam logic [BYTE_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [BYTE_W-1:0] ANY_BYTE  = 8'h3F;
    localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_GAP  = 8'h20;

    typedef enum logic [1:0] {
        FUNC_PAT  = 2'd0,
        FUNC_SUBJ = 2'd1,
        FUNC_EVAL = 2'd2,
        FUNC_CLR  = 2'd3
    } func_t;

    typedef enum logic {
        ENG_IDLE = 1'b0,
        ENG_STEP = 1'b1
    } eng_state_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic matched;
    } eng_status_t;

    function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                   input logic fold);
        logic [BYTE_W-1:0] r;
        r = b;
        if (fold && (b inside {[UPPER_A:UPPER_Z]}))
        begin
            r = b + CASE_GAP;
        end
        return r;
    endfunction

endpackage

/* hdl/wildcard_glob_matcher.sv */
// Top level of the wildcard glob matcher: request decode, length tracking, result register.
`timescale 1ns / 1ps

// Holds a wildcard pattern and a subject string, each loaded one byte per request,
// and on an evaluate request returns one result: matched ('*' matches any run,
// '?' any single byte, optional ASCII case folding) and truncated (a store dropped
// bytes since it was last cleared). Append and clear requests produce no result. An
// evaluate with an empty subject is answered without the matcher; any other
// evaluate runs the matcher, which makes one decision per clock because the
// pattern and subject RAMs each deliver one byte per cycle through their single
// read port. A match leaves the idle state and then takes about subject length +
// pattern length steps without backtracking, and at worst about pattern length x
// subject length steps when stars backtrack. Requests are stalled while the
// matcher runs, and an evaluate is also stalled while the previous result has not
// been taken. Evaluate clears the subject and keeps the pattern. Neither store is
// cleared at reset; only their lengths and drop flags are.

module wildcard_glob_matcher
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int SUBJECT_MAX = SUBJECT_MAX_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        func,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              fold_case,
    output logic              res_valid,
    input  logic              res_stall,
    output logic              matched,
    output logic              truncated
);

    localparam int PLW = $clog2(PATTERN_MAX + 1);
    localparam int SLW = $clog2(SUBJECT_MAX + 1);
    localparam int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int SAW = (SUBJECT_MAX > 1) ? $clog2(SUBJECT_MAX) : 1;
    localparam logic [PLW-1:0] PAT_FULL  = PLW'(PATTERN_MAX);
    localparam logic [SLW-1:0] SUBJ_FULL = SLW'(SUBJECT_MAX);

    logic [PLW-1:0] pat_len_reg, pat_len_next;
    logic [SLW-1:0] subj_len_reg, subj_len_next;
    logic           pat_ovf_reg, pat_ovf_next;
    logic           subj_ovf_reg, subj_ovf_next;
    logic           res_valid_reg, res_valid_next;
    logic           matched_reg, matched_next;
    logic           trunc_reg, trunc_next;

    logic              req_acc;
    func_t             req_func;
    logic              pat_wr, subj_wr, eng_start;
    logic [PAW-1:0]    pat_rd_addr;
    logic [SAW-1:0]    subj_rd_addr;
    logic [BYTE_W-1:0] pat_rd_data, subj_rd_data;
    eng_status_t       eng_status;

    assign req_func  = func_t'(func);
    // Hold requests while matching; hold an evaluate while the last result waits
    assign req_stall = eng_status.busy || (res_valid_reg && (req_func == FUNC_EVAL));
    assign req_acc   = req_valid && !req_stall;

    assign pat_wr    = req_acc && (req_func == FUNC_PAT) && (pat_len_reg != PAT_FULL);
    assign subj_wr   = req_acc && (req_func == FUNC_SUBJ) && (subj_len_reg != SUBJ_FULL);
    assign eng_start = req_acc && (req_func == FUNC_EVAL) && (subj_len_reg != '0);

    always_comb
    begin
        pat_len_next   = pat_len_reg;
        subj_len_next  = subj_len_reg;
        pat_ovf_next   = pat_ovf_reg;
        subj_ovf_next  = subj_ovf_reg;
        res_valid_next = res_valid_reg && res_stall;
        matched_next   = matched_reg;
        trunc_next     = trunc_reg;

        if (req_acc)
        begin
            case (req_func)
                FUNC_PAT:
                begin
                    if (pat_len_reg != PAT_FULL)
                    begin
                        pat_len_next = pat_len_reg + PLW'(1);
                    end
                    else
                    begin
                        pat_ovf_next = 1'b1;
                    end
                end
                FUNC_SUBJ:
                begin
                    if (subj_len_reg != SUBJ_FULL)
                    begin
                        subj_len_next = subj_len_reg + SLW'(1);
                    end
                    else
                    begin
                        subj_ovf_next = 1'b1;
                    end
                end
                FUNC_EVAL:
                begin
                    // flags as they stood before this evaluate
                    trunc_next    = pat_ovf_reg || subj_ovf_reg;
                    subj_ovf_next = 1'b0;
                    if (subj_len_reg == '0)
                    begin
                        // empty subject never matches: answer at once
                        res_valid_next = 1'b1;
                        matched_next   = 1'b0;
                    end
                end
                FUNC_CLR:
                begin
                    pat_len_next = '0;
                    pat_ovf_next = 1'b0;
                end
                default:
                begin
                    pat_len_next = pat_len_reg;
                end
            endcase
        end

        // matcher finished: publish the result and drop the subject
        if (eng_status.done)
        begin
            res_valid_next = 1'b1;
            matched_next   = eng_status.matched;
            subj_len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg   <= '0;
            subj_len_reg  <= '0;
            pat_ovf_reg   <= 1'b0;
            subj_ovf_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pat_len_reg   <= pat_len_next;
            subj_len_reg  <= subj_len_next;
            pat_ovf_reg   <= pat_ovf_next;
            subj_ovf_reg  <= subj_ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        trunc_reg   <= trunc_next;
    end

    assign res_valid = res_valid_reg;
    assign matched   = matched_reg;
    assign truncated = trunc_reg;

    gwm_ram #(
        .DEPTH (PATTERN_MAX),
        .AW    (PAW)
    ) u_pat_ram (
        .clk     (clk),
        .wr_en   (pat_wr),
        .wr_addr (pat_len_reg[PAW-1:0]),
        .wr_data (byte_value),
        .rd_addr (pat_rd_addr),
        .rd_data (pat_rd_data)
    );

    gwm_ram #(
        .DEPTH (SUBJECT_MAX),
        .AW    (SAW)
    ) u_subj_ram (
        .clk     (clk),
        .wr_en   (subj_wr),
        .wr_addr (subj_len_reg[SAW-1:0]),
        .wr_data (byte_value),
        .rd_addr (subj_rd_addr),
        .rd_data (subj_rd_data)
    );

    gwm_engine #(
        .PATTERN_MAX (PATTERN_MAX),
        .SUBJECT_MAX (SUBJECT_MAX),
        .PLW         (PLW),
        .SLW         (SLW),
        .PAW         (PAW),
        .SAW         (SAW)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (eng_start),
        .fold_in      (fold_case),
        .pat_len      (pat_len_reg),
        .subj_len     (subj_len_reg),
        .pat_rd_data  (pat_rd_data),
        .subj_rd_data (subj_rd_data),
        .pat_rd_addr  (pat_rd_addr),
        .subj_rd_addr (subj_rd_addr),
        .status       (eng_status)
    );

    // No request may touch the stores while the matcher walks them
    a_no_req_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.busy |-> !req_acc)
        else $error("request accepted while matcher busy");

    // The result register is free whenever the matcher finishes
    a_res_free_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.done |-> !res_valid_reg)
        else $error("matcher finished over a pending result");

    // A started evaluate occupies the matcher on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_start |=> eng_status.busy)
        else $error("matcher did not start");

    // Every new result leaves the subject empty
    a_subject_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> (subj_len_reg == '0))
        else $error("subject not cleared after evaluate");

endmodule

/* hdl/gwm_ram.sv */
// Byte-wide synchronous RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module gwm_ram
    import gwm_pkg::*;
#(
    parameter int DEPTH = SUBJECT_MAX_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/gwm_engine.sv */
// Match sequencer: walks pattern and subject stores one step per cycle.
`timescale 1ns / 1ps

module gwm_engine
    import gwm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int SUBJECT_MAX = SUBJECT_MAX_DEF,
    parameter int PLW = $clog2(PATTERN_MAX + 1),
    parameter int SLW = $clog2(SUBJECT_MAX + 1),
    parameter int PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1,
    parameter int SAW = (SUBJECT_MAX > 1) ? $clog2(SUBJECT_MAX) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              fold_in,
    input  logic [PLW-1:0]    pat_len,
    input  logic [SLW-1:0]    subj_len,
    input  logic [BYTE_W-1:0] pat_rd_data,
    input  logic [BYTE_W-1:0] subj_rd_data,
    output logic [PAW-1:0]    pat_rd_addr,
    output logic [SAW-1:0]    subj_rd_addr,
    output eng_status_t       status
);

    eng_state_t state_reg, state_next;

    logic [PLW-1:0] p_reg, p_next, star_p_reg, star_p_next, p_inc;
    logic [SLW-1:0] s_reg, s_next, star_s_reg, star_s_next, s_inc;
    logic           have_reg, have_next;
    logic           fold_reg, fold_next;
    logic           fin, fin_match;
    logic           p_lt, s_lt, is_star, byte_ok;

    assign p_lt    = p_reg < pat_len;
    assign s_lt    = s_reg < subj_len;
    assign is_star = p_lt && (pat_rd_data == STAR_BYTE);
    assign byte_ok = p_lt && ((pat_rd_data == ANY_BYTE) ||
                     (fold_byte(pat_rd_data, fold_reg) == fold_byte(subj_rd_data, fold_reg)));
    assign p_inc   = p_reg + PLW'(1);
    assign s_inc   = s_reg + SLW'(1);

    // Step datapath: one decision of the greedy matcher per cycle
    always_comb
    begin
        p_next      = p_reg;
        s_next      = s_reg;
        star_p_next = star_p_reg;
        star_s_next = star_s_reg;
        have_next   = have_reg;
        fold_next   = fold_reg;
        fin         = 1'b0;
        fin_match   = 1'b0;
        case (state_reg)
            ENG_IDLE:
            begin
                p_next    = '0;
                s_next    = '0;
                have_next = 1'b0;
                fold_next = fold_in;
            end
            ENG_STEP:
            begin
                if (!s_lt)
                begin
                    // subject used up: skip trailing stars
                    if (is_star)
                    begin
                        p_next = p_inc;
                    end
                    else
                    begin
                        fin       = 1'b1;
                        fin_match = !p_lt;
                    end
                end
                else if (is_star)
                begin
                    p_next = p_inc;
                    if (p_inc >= pat_len)
                    begin
                        fin       = 1'b1;
                        fin_match = 1'b1;
                    end
                    else
                    begin
                        star_p_next = p_inc;
                        star_s_next = s_inc;
                        have_next   = 1'b1;
                    end
                end
                else if (byte_ok)
                begin
                    p_next = p_inc;
                    s_next = s_inc;
                end
                else if (!have_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    // backtrack to the last star, let it swallow one more byte
                    p_next      = star_p_reg;
                    s_next      = star_s_reg;
                    star_s_next = star_s_reg + SLW'(1);
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE:
            begin
                if (start)
                begin
                    state_next = ENG_STEP;
                end
            end
            ENG_STEP:
            begin
                if (fin)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status.busy    = 1'b0;
        status.done    = 1'b0;
        status.matched = 1'b0;
        case (state_reg)
            ENG_IDLE:
            begin
                status.busy = 1'b0;
            end
            ENG_STEP:
            begin
                status.busy    = 1'b1;
                status.done    = fin;
                status.matched = fin_match;
            end
            default:
            begin
                status.busy = 1'b0;
            end
        endcase
    end

    // Read next step's bytes so they land with the next decision
    assign pat_rd_addr  = p_next[PAW-1:0];
    assign subj_rd_addr = s_next[SAW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        s_reg      <= s_next;
        star_p_reg <= star_p_next;
        star_s_reg <= star_s_next;
        have_reg   <= have_next;
        fold_reg   <= fold_next;
    end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the wildcard glob matcher: directed table, random requests.
`timescale 1ns / 1ps

module tb_top;
    import gwm_pkg::*;

    // Store sizes follow the block's default parameters.
    localparam int PAT_CAP          = PATTERN_MAX_DEF;
    localparam int SUBJ_CAP         = SUBJECT_MAX_DEF;

    // Run shape: request count, the point where the sender drains mid-run, and the
    // long receiver hold-off.
    localparam int REQUEST_TARGET   = 1200;
    localparam int MID_DRAIN_AT     = 600;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 32;
    // At most three full 64 x 256 backtracking matches plus ~1200 requests under random
    // stalls stay far below this.
    localparam int CYCLE_LIMIT      = 2_000_000;
    localparam int DIRECTED_ROWS    = 26;

    // One row of the directed table. Rows with typed set carry their own answer;
    // all other evaluates are checked against the predictor.
    typedef struct {
        func_t             op;
        logic [BYTE_W-1:0] val;
        bit                fold;
        int                reps;
        bit                typed;
        bit                exp_hit;
        bit                exp_trunc;
    } stim_row_t;

    typedef struct packed {
        logic hit;
        logic trunc;
    } verdict_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_stall;
    func_t             req_func   = FUNC_PAT;
    logic [BYTE_W-1:0] byte_value = '0;
    logic              fold_case  = 1'b0;
    logic              res_valid;
    logic              res_stall  = 1'b0;
    logic              matched;
    logic              truncated;

    wildcard_glob_matcher DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .func       (req_func),
        .byte_value (byte_value),
        .fold_case  (fold_case),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .matched    (matched),
        .truncated  (truncated)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of both stores, lengths and drop flags.
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] pat_mem  [PAT_CAP];
    logic [BYTE_W-1:0] subj_mem [SUBJ_CAP];
    int                pat_len      = 0;
    int                subj_len     = 0;
    bit                pat_dropped  = 1'b0;
    bit                subj_dropped = 1'b0;

    verdict_t          awaited_verdicts [$];
    int                fail_count   = 0;
    int                cycle_count  = 0;
    int                burst_left   = 0;
    int                requests_sent = 0;
    int                big_left     = 3;
    bit                long_hold_req  = 1'b0;
    bit                long_hold_done = 1'b0;

    stim_row_t         directed_rows [DIRECTED_ROWS];

    // 250 MHz clock.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("wildcard_glob_matcher verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------

    // Fold ASCII A-Z onto a-z when folding is on; every other byte passes as is.
    function automatic logic [BYTE_W-1:0] lower_ascii(logic [BYTE_W-1:0] c, bit fold);
        if (fold && c >= UPPER_A && c <= UPPER_Z)
        begin
            return c + CASE_GAP;
        end
        return c;
    endfunction

    function automatic bit star_at(int p);
        return p < pat_len && pat_mem[p] == STAR_BYTE;
    endfunction

    // A position past the pattern's end never matches a subject byte.
    function automatic bit byte_fits(int p, int s, bit fold);
        if (p >= pat_len)
        begin
            return 1'b0;
        end
        if (pat_mem[p] == ANY_BYTE)
        begin
            return 1'b1;
        end
        return lower_ascii(pat_mem[p], fold) == lower_ascii(subj_mem[s], fold);
    endfunction

    // Greedy glob match: walk the literal prefix, then scan with a restart point
    // just past the most recent star.
    function automatic bit glob_verdict(bit fold);
        int p;
        int s;
        int star_p;
        int star_s;
        bit have_star;
        p = 0;
        s = 0;
        star_p = 0;
        star_s = 0;
        have_star = 1'b0;
        if (subj_len == 0)
        begin
            return 1'b0;
        end
        while (s < subj_len && !star_at(p))
        begin
            if (!byte_fits(p, s, fold))
            begin
                return 1'b0;
            end
            p++;
            s++;
        end
        while (s < subj_len)
        begin
            if (star_at(p))
            begin
                p++;
                // A trailing star swallows the rest of the subject.
                if (p >= pat_len)
                begin
                    return 1'b1;
                end
                star_p = p;
                star_s = s + 1;
                have_star = 1'b1;
            end
            else if (byte_fits(p, s, fold))
            begin
                p++;
                s++;
            end
            else
            begin
                if (!have_star)
                begin
                    return 1'b0;
                end
                // Let the last star eat one more byte and retry.
                p = star_p;
                s = star_s;
                star_s++;
            end
        end
        while (star_at(p))
        begin
            p++;
        end
        return p >= pat_len;
    endfunction

    // Advance the predictor by one accepted request; queue the verdict of an evaluate.
    // A typed row replaces the predicted verdict with the one written in the table.
    function automatic void model_request(func_t op, logic [BYTE_W-1:0] val, bit fold,
                                          bit typed, verdict_t typed_v);
        verdict_t v;
        case (op)
            FUNC_PAT:
            begin
                if (pat_len < PAT_CAP)
                begin
                    pat_mem[pat_len] = val;
                    pat_len++;
                end
                else
                begin
                    pat_dropped = 1'b1;
                end
            end
            FUNC_SUBJ:
            begin
                if (subj_len < SUBJ_CAP)
                begin
                    subj_mem[subj_len] = val;
                    subj_len++;
                end
                else
                begin
                    subj_dropped = 1'b1;
                end
            end
            FUNC_EVAL:
            begin
                v.hit   = glob_verdict(fold);
                v.trunc = pat_dropped | subj_dropped;
                awaited_verdicts.push_back(typed ? typed_v : v);
                // Evaluate empties the subject and keeps the pattern.
                subj_len = 0;
                subj_dropped = 1'b0;
            end
            FUNC_CLR:
            begin
                pat_len = 0;
                pat_dropped = 1'b0;
            end
            default:
            begin
                pat_len = pat_len;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side. Work in bursts of random length separated by random gaps;
    // hold the payload steady while the block stalls.
    // ------------------------------------------------------------------
    task automatic send_request(func_t op, logic [BYTE_W-1:0] val, bit fold,
                                bit typed = 1'b0, verdict_t typed_v = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid  <= 1'b1;
        req_func   <= op;
        byte_value <= val;
        fold_case  <= fold;
        // Stall is read before this edge's updates land, as the block sees it.
        do
            @(posedge clk);
        while (req_stall);
        requests_sent++;
        model_request(op, val, fold, typed, typed_v);
    endtask

    // Drop valid and hold until every awaited verdict has come back.
    task automatic drain_verdicts();
        req_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaited_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Bytes that exercise the matcher: both wildcards, letters in both cases, and
    // now and then any byte at all.
    function automatic logic [BYTE_W-1:0] glob_char();
        case ($urandom_range(0, 7))
            0:       return STAR_BYTE;
            1:       return ANY_BYTE;
            2:       return 8'h61;
            3:       return 8'h62;
            4:       return UPPER_A;
            5:       return UPPER_A + 8'd1;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Random requests of any kind.
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            send_request(func_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // A well-formed sequence: maybe a fresh pattern, a subject (mostly built to fit
    // the pattern, sometimes with one byte spoiled), then evaluate.
    task automatic random_sentence();
        logic [BYTE_W-1:0] subj_q [$];
        logic [BYTE_W-1:0] c;
        int n;
        int i;
        bit big;
        bit letter;
        big = (big_left > 0) && ($urandom_range(0, 29) == 0);
        if (big)
        begin
            big_left--;
        end
        if (big || $urandom_range(0, 2) == 0)
        begin
            send_request(FUNC_CLR, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            n = big ? $urandom_range(PAT_CAP - 4, PAT_CAP + 4) : $urandom_range(0, 8);
            for (i = 0; i < n; i++)
            begin
                send_request(FUNC_PAT, glob_char(), 1'($urandom_range(0, 1)));
            end
        end
        if ($urandom_range(0, 3) != 0)
        begin
            for (i = 0; i < pat_len; i++)
            begin
                c = pat_mem[i];
                letter = (c >= UPPER_A && c <= UPPER_Z) ||
                         (c >= UPPER_A + CASE_GAP && c <= UPPER_Z + CASE_GAP);
                if (c == STAR_BYTE)
                begin
                    n = $urandom_range(0, 3);
                    repeat (n) subj_q.push_back(glob_char());
                end
                else if (c == ANY_BYTE)
                begin
                    subj_q.push_back(glob_char());
                end
                else if (letter && $urandom_range(0, 3) == 0)
                begin
                    subj_q.push_back(c ^ CASE_GAP);
                end
                else
                begin
                    subj_q.push_back(c);
                end
            end
            if (subj_q.size() > 0 && $urandom_range(0, 4) == 0)
            begin
                subj_q[$urandom_range(0, subj_q.size() - 1)] = glob_char();
            end
        end
        else
        begin
            n = $urandom_range(0, 10);
            repeat (n) subj_q.push_back(glob_char());
        end
        if (big)
        begin
            // Fill the subject store to the brim, sometimes past it.
            n = $urandom_range(SUBJ_CAP - 6, SUBJ_CAP + 4);
            while (subj_q.size() < n)
            begin
                subj_q.push_back(glob_char());
            end
        end
        foreach (subj_q[k])
        begin
            send_request(FUNC_SUBJ, subj_q[k], 1'($urandom_range(0, 1)));
        end
        send_request(FUNC_EVAL, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Result side. Stall on a pattern of its own: free-running, light, heavy or
    // alternating stretches, plus one long hold-off once the random phase starts.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                // Hold off long enough for the block to fill and stall requests.
                long_hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                res_stall <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                case (mode)
                    0:       res_stall <= 1'b0;
                    1:       res_stall <= ($urandom_range(0, 2) == 0);
                    2:       res_stall <= ($urandom_range(0, 3) != 0);
                    default: res_stall <= ~res_stall;
                endcase
            end
        end
    end

    // Compare every taken result with the oldest awaited verdict.
    always @(posedge clk)
    begin : verdict_check
        verdict_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (awaited_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result: matched=%0b truncated=%0b",
                         $time, matched, truncated);
                fail_count++;
            end
            else
            begin
                want = awaited_verdicts.pop_front();
                if (matched !== want.hit)
                begin
                    $display("%0t: matched mismatch: expected %0b, got %0b",
                             $time, want.hit, matched);
                    fail_count++;
                end
                if (truncated !== want.trunc)
                begin
                    $display("%0t: truncated mismatch: expected %0b, got %0b",
                             $time, want.trunc, truncated);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random phase, drain.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        verdict_t typed_v;
        bit       mid_drained;
        int       r;
        int       k;
        mid_drained = 1'b0;

        directed_rows = '{
            // Right after reset: empty subject and empty pattern never match.
            '{FUNC_EVAL, 8'h00,     1'b0, 1,   1'b1, 1'b0, 1'b0},
            // Empty pattern against a one-byte subject.
            '{FUNC_SUBJ, 8'h71,     1'b1, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_EVAL, 8'h00,     1'b0, 1,   1'b1, 1'b0, 1'b0},
            // Pattern: upper-case letter, star, any-byte, zero byte.
            '{FUNC_PAT,  UPPER_A,   1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_PAT,  STAR_BYTE, 1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_PAT,  ANY_BYTE,  1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_PAT,  8'h00,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            // Lower-case subject, folded compare, star has to backtrack.
            '{FUNC_SUBJ, 8'h61,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_SUBJ, 8'h78,     1'b0, 3,   1'b0, 1'b0, 1'b0},
            '{FUNC_SUBJ, 8'h00,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_EVAL, 8'hFF,     1'b1, 1,   1'b0, 1'b0, 1'b0},
            // Same letter without folding.
            '{FUNC_SUBJ, 8'h61,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_SUBJ, 8'h00,     1'b0, 2,   1'b0, 1'b0, 1'b0},
            '{FUNC_EVAL, 8'h00,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            // Overfill both stores: one byte dropped from each.
            '{FUNC_CLR,  8'hAA,     1'b1, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_PAT,  8'h61,     1'b0, 65,  1'b0, 1'b0, 1'b0},
            '{FUNC_SUBJ, 8'h61,     1'b0, 257, 1'b0, 1'b0, 1'b0},
            '{FUNC_EVAL, 8'h00,     1'b0, 1,   1'b1, 1'b0, 1'b1},
            // Pattern drop persists across evaluate; star in a subject is literal.
            '{FUNC_SUBJ, STAR_BYTE, 1'b1, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_EVAL, 8'h00,     1'b1, 1,   1'b0, 1'b0, 1'b0},
            // Clear pattern, then a leading star that must skip a run.
            '{FUNC_CLR,  8'h55,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_PAT,  STAR_BYTE, 1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_PAT,  8'h62,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_SUBJ, 8'h61,     1'b0, 3,   1'b0, 1'b0, 1'b0},
            '{FUNC_SUBJ, 8'h62,     1'b0, 1,   1'b0, 1'b0, 1'b0},
            '{FUNC_EVAL, 8'h00,     1'b1, 1,   1'b0, 1'b0, 1'b0}
        };

        // Hold reset low from the start and release it on an edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            typed_v.hit   = directed_rows[r].exp_hit;
            typed_v.trunc = directed_rows[r].exp_trunc;
            for (k = 0; k < directed_rows[r].reps; k++)
            begin
                send_request(directed_rows[r].op, directed_rows[r].val, directed_rows[r].fold,
                             directed_rows[r].typed, typed_v);
            end
        end
        drain_verdicts();

        // Arm the receiver's long hold-off and keep offering requests meanwhile.
        long_hold_req = 1'b1;
        while (requests_sent < REQUEST_TARGET)
        begin
            if (!mid_drained && requests_sent >= MID_DRAIN_AT)
            begin
                mid_drained = 1'b1;
                drain_verdicts();
            end
            if ($urandom_range(0, 7) == 0)
            begin
                noise_burst();
            end
            else
            begin
                random_sentence();
            end
        end

        // Let the last results come back, then give the block a few idle cycles.
        req_valid <= 1'b0;
        while (awaited_verdicts.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("wildcard_glob_matcher verification clean");
        end
        else
        begin
            $display("wildcard_glob_matcher verification failed");
        end
        $finish;
    end

endmodule
